### rtl/core/rde_pkg.sv
// ============================================================================
// rde_pkg
// Shared sizes, command codes, result type and ring index helpers for the
// reversible deque engine.
// ============================================================================
`default_nettype none

package rde_pkg;

    // Storage geometry
    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int SUM_BITS   = ADDR_BITS + 1;

    // Port field widths
    localparam int OP_BITS    = 2;
    localparam int ELEM_BITS  = 32;

    // Command codes
    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD    = 2'd0,
        OP_REVERSE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    // One result entry as it travels to the output buffer
    typedef struct packed {
        logic [VALUE_BITS-1:0] elem;
        logic                  is_error;
        logic                  is_empty;
        logic                  last;
    } res_t;

    // Output buffer status seen by the controller
    typedef struct packed {
        logic [1:0] occ;
        logic       pop;
    } buf_stat_t;

    // Ring slot a + off, both below DEPTH
    function automatic logic [ADDR_BITS-1:0] addr_add(
        input logic [ADDR_BITS-1:0] a,
        input logic [ADDR_BITS-1:0] off
    );
        logic [SUM_BITS-1:0] sum;
        sum = {1'b0, a} + {1'b0, off};
        if (sum >= SUM_BITS'(DEPTH)) begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

    // Next slot around the ring
    function automatic logic [ADDR_BITS-1:0] addr_inc(input logic [ADDR_BITS-1:0] a);
        return (a == ADDR_BITS'(DEPTH - 1)) ? '0 : a + ADDR_BITS'(1);
    endfunction

    // Previous slot around the ring
    function automatic logic [ADDR_BITS-1:0] addr_dec(input logic [ADDR_BITS-1:0] a);
        return (a == '0) ? ADDR_BITS'(DEPTH - 1) : a - ADDR_BITS'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/core/rde_cmd_if.sv
// ============================================================================
// rde_cmd_if
// Command channel: valid/ready with op and value payload.
// ============================================================================
`default_nettype none

interface rde_cmd_if
    import rde_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   op;
    logic [ELEM_BITS-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/rde_rsp_if.sv
// ============================================================================
// rde_rsp_if
// Result channel: valid/ready with element and marker flags.
// ============================================================================
`default_nettype none

interface rde_rsp_if
    import rde_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] elem;
    logic                 is_error;
    logic                 is_empty;
    logic                 last;

    modport source (output valid, output elem, output is_error, output is_empty,
                    output last, input ready);
    modport sink   (input valid, input elem, input is_error, input is_empty,
                    input last, output ready);
endinterface

`default_nettype wire

### rtl/core/reversible_deque_engine_core.sv
// ============================================================================
// reversible_deque_engine_core
// Ring-buffer deque with lazy reverse; finish drains it in logical order.
// ============================================================================
//
//  port   dir    payload                          request meaning
//  -----  -----  -------------------------------  ---------------------------
//  cmd    sink   op[1:0], value[31:0]             load/reverse/delete/finish
//  rsp    source elem[31:0], is_error, is_empty,  one emitted result
//                last
//
//  Load, reverse and delete act when accepted. A finish emits a single
//  error or empty result, otherwise one result per element, with one memory
//  read per cycle through the single RAM read port while the buffer has room.
//  Reset (rst_n low, asynchronous) clears pointers, flags and the buffer;
//  the element RAM is not cleared. A stalled rsp channel holds the read
//  sequencer once the two-entry result buffer is full; cmd is held off while
//  a finish drains, while a read or marker result is on its way to the buffer,
//  and while the result buffer is full.
// ============================================================================
`default_nettype none

module reversible_deque_engine_core
    import rde_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rde_cmd_if.sink   cmd,
    rde_rsp_if.source rsp
);

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  push;
    res_t                  push_data;
    buf_stat_t             stat;

    // Pointer control and drain sequencer
    rde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .push      (push),
        .push_data (push_data),
        .stat      (stat)
    );

    // Element store
    rde_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (VALUE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result buffer
    rde_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### rtl/core/rde_ram.sv
// ============================================================================
// rde_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module rde_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 32,
    localparam int AW     = $clog2(DEPTH_P)
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [WIDTH_P-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/rde_out_buf.sv
// ============================================================================
// rde_out_buf
// Two-entry result buffer between the controller and the result channel.
// ============================================================================
`default_nettype none

module rde_out_buf
    import rde_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire res_t   push_data,
    output buf_stat_t   stat,
    rde_rsp_if.source   rsp
);

    res_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] occ_reg;
    logic       pop;
    res_t       head;

    assign pop  = rsp.valid && rsp.ready;
    assign head = ent_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            occ_reg <= occ_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rsp.valid    = (occ_reg != '0);
    assign rsp.elem     = ELEM_BITS'(head.elem);
    assign rsp.is_error = head.is_error;
    assign rsp.is_empty = head.is_empty;
    assign rsp.last     = head.last;

    assign stat.occ = occ_reg;
    assign stat.pop = pop;

endmodule

`default_nettype wire

### rtl/core/rde_ctrl.sv
// ============================================================================
// rde_ctrl
// Deque pointers, direction and error flags, and the finish read sequencer.
// ============================================================================
`default_nettype none

module rde_ctrl
    import rde_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rde_cmd_if.sink                    cmd,
    output logic                       ram_we,
    output logic      [ADDR_BITS-1:0]  ram_waddr,
    output logic      [VALUE_BITS-1:0] ram_wdata,
    output logic                       ram_re,
    output logic      [ADDR_BITS-1:0]  ram_raddr,
    input  wire logic [VALUE_BITS-1:0] ram_rdata,
    output logic                       push,
    output res_t                       push_data,
    input  wire buf_stat_t             stat
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                 state_reg,     state_next;
    logic [ADDR_BITS-1:0]   head_reg,      head_next;
    logic [CNT_BITS-1:0]    count_reg,     count_next;
    logic                   rev_reg,       rev_next;
    logic                   err_reg,       err_next;
    logic [ADDR_BITS-1:0]   emit_addr_reg, emit_addr_next;
    logic [CNT_BITS-1:0]    emit_left_reg, emit_left_next;
    logic                   emit_dir_reg,  emit_dir_next;
    logic                   rd_pend_reg,   rd_pend_next;
    logic                   rd_last_reg,   rd_last_next;
    logic                   spec_pend_reg, spec_pend_next;
    logic                   spec_err_reg,  spec_err_next;

    logic                   accept;
    op_t                    op;
    logic [2:0]             fill;
    logic                   can_issue;
    logic [ADDR_BITS-1:0]   cnt_lo;
    logic [ADDR_BITS-1:0]   cnt_m1;

    assign op     = op_t'(cmd.op);
    assign accept = cmd.valid && cmd.ready;
    assign cnt_lo = count_reg[ADDR_BITS-1:0];
    assign cnt_m1 = cnt_lo - ADDR_BITS'(1);

    // Commands only from idle, with nothing in flight and buffer room
    assign cmd.ready = (state_reg == ST_IDLE) && !rd_pend_reg && !spec_pend_reg
                       && (stat.occ != 2'd2);

    // Read credit: buffer entries plus reads in flight, net of this cycle's pop
    assign fill      = {1'b0, stat.occ} + {2'b00, rd_pend_reg};
    assign can_issue = (fill < 3'd2) || ((fill == 3'd2) && stat.pop);

    // Result push: RAM data or a single error/empty marker
    assign push = rd_pend_reg || spec_pend_reg;
    always_comb
    begin
        if (rd_pend_reg)
        begin
            push_data = '{elem: ram_rdata, is_error: 1'b0, is_empty: 1'b0,
                          last: rd_last_reg};
        end
        else
        begin
            push_data = '{elem: '0, is_error: spec_err_reg, is_empty: !spec_err_reg,
                          last: 1'b1};
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        err_next       = err_reg;
        emit_addr_next = emit_addr_reg;
        emit_left_next = emit_left_reg;
        emit_dir_next  = emit_dir_reg;
        rd_pend_next   = 1'b0;
        rd_last_next   = rd_last_reg;
        spec_pend_next = 1'b0;
        spec_err_next  = spec_err_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_add(head_reg, cnt_lo);
        ram_wdata      = cmd.value[VALUE_BITS-1:0];
        ram_re         = 1'b0;
        ram_raddr      = emit_addr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_FINISH:
                        begin
                            if (err_reg)
                            begin
                                spec_pend_next = 1'b1;
                                spec_err_next  = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                spec_pend_next = 1'b1;
                                spec_err_next  = 1'b0;
                            end
                            else
                            begin
                                state_next     = ST_EMIT;
                                emit_addr_next = rev_reg ? addr_add(head_reg, cnt_m1)
                                                         : head_reg;
                                emit_dir_next  = rev_reg;
                                emit_left_next = count_reg;
                            end
                            head_next  = '0;
                            count_next = '0;
                            rev_next   = 1'b0;
                            err_next   = 1'b0;
                        end
                        OP_LOAD:
                        begin
                            if (!err_reg && (count_reg != CNT_BITS'(DEPTH)))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_BITS'(1);
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (!err_reg)
                            begin
                                rev_next = !rev_reg;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!err_reg)
                            begin
                                if (count_reg == '0)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    if (!rev_reg)
                                    begin
                                        head_next = addr_inc(head_reg);
                                    end
                                    count_next = count_reg - CNT_BITS'(1);
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (can_issue)
                begin
                    ram_re         = 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_last_next   = (emit_left_reg == CNT_BITS'(1));
                    emit_left_next = emit_left_reg - CNT_BITS'(1);
                    emit_addr_next = emit_dir_reg ? addr_dec(emit_addr_reg)
                                                  : addr_inc(emit_addr_reg);
                    if (emit_left_reg == CNT_BITS'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            emit_addr_reg <= '0;
            emit_left_reg <= '0;
            emit_dir_reg  <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            spec_pend_reg <= 1'b0;
            spec_err_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            err_reg       <= err_next;
            emit_addr_reg <= emit_addr_next;
            emit_left_reg <= emit_left_next;
            emit_dir_reg  <= emit_dir_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            spec_pend_reg <= spec_pend_next;
            spec_err_reg  <= spec_err_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rde_checker.sv
// ============================================================================
// rde_checker
// Port-level checks on the deque engine, bound to the top level.
// ============================================================================
`default_nettype none

module rde_checker
    import rde_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cmd_valid,
    input wire logic                 cmd_ready,
    input wire logic [OP_BITS-1:0]   cmd_op,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic [ELEM_BITS-1:0] rsp_elem,
    input wire logic                 rsp_is_error,
    input wire logic                 rsp_is_empty,
    input wire logic                 rsp_last
);

    // Error result is a lone, zeroed, final result
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_error |-> rsp_last && !rsp_is_empty && (rsp_elem == '0))
        else $error("error result not single and zeroed");

    // Empty result is a lone, zeroed, final result
    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> rsp_last && !rsp_is_error && (rsp_elem == '0))
        else $error("empty result not single and zeroed");

    // A finish request blocks the next command cycle
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_op == OP_FINISH) |=> !cmd_ready)
        else $error("command taken right after a finish");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elem) && $stable(rsp_last))
        else $error("stalled result changed");

endmodule

bind reversible_deque_engine_core rde_checker u_rde_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_op       (cmd.op),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_elem     (rsp.elem),
    .rsp_is_error (rsp.is_error),
    .rsp_is_empty (rsp.is_empty),
    .rsp_last     (rsp.last)
);

`default_nettype wire

### dv/reversible_deque_engine_core_tb.sv
// ============================================================================
// reversible_deque_engine_core_tb
// Self-checking bench for the reversible deque engine. A scoreboard keeps its
// own copy of the ring, the direction and the error flag, predicts the
// results of every accepted finish, and checks each result on the output
// channel in order. Directed cases come first, then a ring fill with wrap,
// then random command sequences, mostly with random gaps on both channels.
// ============================================================================

class deque_scoreboard;

    rde_pkg::res_t expected_q[$];
    logic [rde_pkg::VALUE_BITS-1:0] slot_val [rde_pkg::DEPTH];
    int unsigned head;
    int unsigned count;
    bit reversed;
    bit err_seen;
    int mismatches;

    function new();
        clear_deque();
        mismatches = 0;
    endfunction

    function void clear_deque();
        head     = 0;
        count    = 0;
        reversed = 1'b0;
        err_seen = 1'b0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Update the deque copy with one accepted request; queue what a finish emits
    function void note_request(rde_pkg::op_t op, logic [31:0] value);
        rde_pkg::res_t r;
        int unsigned k;
        int unsigned off;
        if (op == rde_pkg::OP_FINISH) begin
            r = '0;
            r.last = 1'b1;
            if (err_seen) begin
                r.is_error = 1'b1;
                expected_q.insert(expected_q.size(), r);
            end
            else if (count == 0) begin
                r.is_empty = 1'b1;
                expected_q.insert(expected_q.size(), r);
            end
            else begin
                for (k = 0; k < count; k++) begin
                    off    = reversed ? (count - 1 - k) : k;
                    r      = '0;
                    r.elem = slot_val[(head + off) % rde_pkg::DEPTH];
                    r.last = (k + 1 == count);
                    expected_q.insert(expected_q.size(), r);
                end
            end
            clear_deque();
            return;
        end
        // everything but finish is dropped after an error
        if (err_seen)
            return;
        case (op)
            rde_pkg::OP_LOAD:
            begin
                if (count < rde_pkg::DEPTH) begin
                    slot_val[(head + count) % rde_pkg::DEPTH] = value;
                    count++;
                end
            end
            rde_pkg::OP_REVERSE:
            begin
                reversed = !reversed;
            end
            default:
            begin
                if (count == 0)
                    err_seen = 1'b1;
                else begin
                    if (!reversed)
                        head = (head + 1) % rde_pkg::DEPTH;
                    count--;
                end
            end
        endcase
    endfunction

    function void report(string what, rde_pkg::res_t exp_r, rde_pkg::res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: exp elem=%h err=%b empty=%b last=%b, got elem=%h err=%b empty=%b last=%b",
                     $time, what, exp_r.elem, exp_r.is_error, exp_r.is_empty, exp_r.last,
                     got.elem, got.is_error, got.is_empty, got.last);
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(rde_pkg::res_t got);
        rde_pkg::res_t exp_r;
        if (expected_q.size() == 0) begin
            report("result with nothing pending", '0, got);
            return;
        end
        exp_r = expected_q[0];
        expected_q.delete(0);
        if (got.elem !== exp_r.elem || got.is_error !== exp_r.is_error ||
            got.is_empty !== exp_r.is_empty || got.last !== exp_r.last)
            report("result mismatch", exp_r, got);
    endfunction

endclass

module reversible_deque_engine_core_tb;

    import rde_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int ITEM_TARGET    = 165;

    logic clk;
    logic rst_n;

    rde_cmd_if cmd_ch ();
    rde_rsp_if rsp_ch ();

    deque_scoreboard sb = new();

    bit tx_quiet;
    bit rx_quiet;
    int sent_count;
    int stall_left;

    reversible_deque_engine_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 45);
    endfunction

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
            stall_left   <= pick_gap();
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Result monitor
    always @(posedge clk)
    begin : result_monitor
        res_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.elem     = rsp_ch.elem;
            got.is_error = rsp_ch.is_error;
            got.is_empty = rsp_ch.is_empty;
            got.last     = rsp_ch.last;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run after a long stretch with no request moving
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("reversible_deque_engine_core verification failed");
        $finish;
    end

    // Send one command request; returns at the edge that accepted it
    task automatic send_cmd(input op_t op, input logic [31:0] value);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.value <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_request(op, value);
        sent_count++;
    endtask

    // Hold off commands until every predicted result has arrived
    task automatic wait_drained(input int extra);
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // One well-formed command run closed by a finish
    task automatic send_run(input int len);
        int i;
        int r;
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_cmd(OP_LOAD, $urandom());
            else if (r < 72)
                send_cmd(OP_REVERSE, $urandom());
            else
                send_cmd(OP_DELETE, $urandom());
        end
        send_cmd(OP_FINISH, $urandom());
    endtask

    // Stimulus
    initial
    begin : stimulus
        int i;
        int n;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        sent_count   = 0;
        stall_left   = 0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op    = OP_LOAD;
        cmd_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finish on an empty store
        send_cmd(OP_FINISH, 32'h0);
        // delete on empty sets the error; later commands up to the finish are ignored
        send_cmd(OP_DELETE, 32'h0);
        send_cmd(OP_LOAD, 32'h1234_5678);
        send_cmd(OP_REVERSE, 32'h0);
        send_cmd(OP_FINISH, 32'hFFFF_FFFF);
        // value extremes, load while reversed, delete from the back
        send_cmd(OP_LOAD, 32'h0000_0000);
        send_cmd(OP_LOAD, 32'hFFFF_FFFF);
        send_cmd(OP_LOAD, 32'hAAAA_AAAA);
        send_cmd(OP_REVERSE, 32'h0);
        send_cmd(OP_LOAD, 32'h5555_5555);
        send_cmd(OP_DELETE, 32'h0);
        send_cmd(OP_FINISH, 32'h0);
        // delete down to empty with a moved head
        send_cmd(OP_LOAD, 32'h8000_0001);
        send_cmd(OP_DELETE, 32'h0);
        send_cmd(OP_FINISH, 32'h0);
        // reversed store emptied, then one delete too many
        send_cmd(OP_LOAD, 32'h0F0F_F0F0);
        send_cmd(OP_REVERSE, 32'h0);
        send_cmd(OP_DELETE, 32'h0);
        send_cmd(OP_DELETE, 32'h0);
        send_cmd(OP_FINISH, 32'h0);
        wait_drained(SETTLE_CYCLES);

        // fill with the head moved so the ring wraps, overflow drops one load
        tx_quiet = 1'b1;
        for (i = 0; i < 4; i++)
            send_cmd(OP_LOAD, $urandom());
        for (i = 0; i < 3; i++)
            send_cmd(OP_DELETE, $urandom());
        for (i = 0; i < DEPTH; i++)
            send_cmd(OP_LOAD, $urandom());
        tx_quiet = 1'b0;
        send_cmd(OP_REVERSE, $urandom());
        send_cmd(OP_DELETE, $urandom());
        send_cmd(OP_LOAD, $urandom());
        send_cmd(OP_FINISH, $urandom());
        wait_drained(SETTLE_CYCLES);

        // random runs, with some noise and a few quiet stretches
        n = 0;
        while (sent_count < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
                send_run($urandom_range(1, 10));
            else begin
                for (i = $urandom_range(1, 6); i > 0; i--)
                    send_cmd(op_t'($urandom_range(0, 3)), $urandom());
            end
            n++;
            if (n == 4 || $urandom_range(0, 9) == 0)
                wait_drained(SETTLE_CYCLES);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_cmd(OP_FINISH, $urandom());
        cmd_ch.valid <= 1'b0;

        // wait out the tail
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d predicted results never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("reversible_deque_engine_core verification clean");
        else
            $display("reversible_deque_engine_core verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rde_pkg.sv
rtl/core/rde_cmd_if.sv
rtl/core/rde_rsp_if.sv
rtl/core/rde_ram.sv
rtl/core/rde_out_buf.sv
rtl/core/rde_ctrl.sv
rtl/core/reversible_deque_engine_core.sv
rtl/core/rde_checker.sv
dv/reversible_deque_engine_core_tb.sv
